// ===== src/acf_pkg.sv =====
package acf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam int XY_W = 36;
  localparam int Z_W = 27;
  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic signed [XY_W-1:0] CORDIC_K = 36'sd652032874;
  localparam logic signed [Z_W-1:0] HALF_TURN_FINE = 27'sd11796480;
  localparam logic signed [19:0] HALF_TURN = 20'sd11520;
  localparam logic signed [19:0] TURN = 20'sd23040;
  localparam logic signed [19:0] QUARTER_TURN = 20'sd5760;

  localparam logic [1:0] REG_GYRO_WEIGHT = 2'd0;
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd1;
  localparam logic [1:0] REG_DECLINATION = 2'd2;
  localparam logic [1:0] REG_HEADING_WEIGHT = 2'd3;

  typedef struct packed {
    logic start;
    logic vec;
    logic signed [XY_W-1:0] x0;
    logic signed [XY_W-1:0] y0;
    logic signed [Z_W-1:0] z0;
  } acf_cordic_cmd_t;

  typedef struct packed {
    logic done;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } acf_cordic_res_t;

  typedef enum logic [39:0] {
    S_IDLE = 40'd1 << 0,
    S_SQ1  = 40'd1 << 1,
    S_SQ2  = 40'd1 << 2,
    S_SQ3  = 40'd1 << 3,
    S_SQ4  = 40'd1 << 4,
    S_RT1  = 40'd1 << 5,
    S_RT2  = 40'd1 << 6,
    S_RT3  = 40'd1 << 7,
    S_GX   = 40'd1 << 8,
    S_GX2  = 40'd1 << 9,
    S_GY2  = 40'd1 << 10,
    S_BL1  = 40'd1 << 11,
    S_BL2  = 40'd1 << 12,
    S_BL3  = 40'd1 << 13,
    S_BL4  = 40'd1 << 14,
    S_BL5  = 40'd1 << 15,
    S_SAT  = 40'd1 << 16,
    S_SC0  = 40'd1 << 17,
    S_SC1  = 40'd1 << 18,
    S_SC2  = 40'd1 << 19,
    S_SC3  = 40'd1 << 20,
    S_SC4  = 40'd1 << 21,
    S_WRAP = 40'd1 << 22,
    S_HM1  = 40'd1 << 23,
    S_HM2  = 40'd1 << 24,
    S_HM3  = 40'd1 << 25,
    S_HM4  = 40'd1 << 26,
    S_HM5  = 40'd1 << 27,
    S_HM6  = 40'd1 << 28,
    S_HM7  = 40'd1 << 29,
    S_HM8  = 40'd1 << 30,
    S_HM9  = 40'd1 << 31,
    S_HW   = 40'd1 << 32,
    S_YW0  = 40'd1 << 33,
    S_YW1  = 40'd1 << 34,
    S_YW2  = 40'd1 << 35,
    S_YW3  = 40'd1 << 36,
    S_YW4  = 40'd1 << 37,
    S_YW5  = 40'd1 << 38,
    S_DONE = 40'd1 << 39
  } acf_state_t;

  function automatic logic signed [Z_W-1:0] atan_entry(logic [4:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = 27'sd2949120;
      5'd1:  v = 27'sd1740967;
      5'd2:  v = 27'sd919879;
      5'd3:  v = 27'sd466945;
      5'd4:  v = 27'sd234379;
      5'd5:  v = 27'sd117304;
      5'd6:  v = 27'sd58666;
      5'd7:  v = 27'sd29335;
      5'd8:  v = 27'sd14668;
      5'd9:  v = 27'sd7334;
      5'd10: v = 27'sd3667;
      5'd11: v = 27'sd1833;
      5'd12: v = 27'sd917;
      5'd13: v = 27'sd458;
      5'd14: v = 27'sd229;
      5'd15: v = 27'sd115;
      5'd16: v = 27'sd57;
      5'd17: v = 27'sd29;
      5'd18: v = 27'sd14;
      5'd19: v = 27'sd7;
      5'd20: v = 27'sd4;
      5'd21: v = 27'sd2;
      5'd22: v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/acf_in_if.sv =====
interface acf_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [15:0] mag_z;

  modport source(output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 mag_x, mag_y, mag_z, input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
               mag_x, mag_y, mag_z, output ready);
endinterface

// ===== src/acf_out_if.sv =====
interface acf_out_if;
  logic valid;
  logic ready;
  logic attitude_valid;
  logic signed [15:0] roll_out;
  logic signed [15:0] pitch_out;
  logic signed [14:0] yaw_out;
  logic signed [15:0] roll_rate;
  logic signed [15:0] pitch_rate;
  logic signed [15:0] yaw_rate;
  logic [15:0] accel_magnitude;
  logic signed [14:0] mag_heading;

  modport source(output valid, attitude_valid, roll_out, pitch_out, yaw_out, roll_rate,
                 pitch_rate, yaw_rate, accel_magnitude, mag_heading, input ready);
  modport sink(input valid, attitude_valid, roll_out, pitch_out, yaw_out, roll_rate,
               pitch_rate, yaw_rate, accel_magnitude, mag_heading, output ready);
endinterface

// ===== src/acf_cordic.sv =====
module acf_cordic
  import acf_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  acf_cordic_cmd_t cmd,
  output acf_cordic_res_t res
);

  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [Z_W-1:0] z;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic done;
  logic vec;
  logic zflag;

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0] tab;
  logic plus;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign tab = atan_entry(5'(cnt));
  assign plus = vec ? !y[XY_W-1] : z[Z_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt <= '0;
        vec <= cmd.vec;
        zflag <= cmd.vec && cmd.x0 == '0 && cmd.y0 == '0;
        if (cmd.vec && cmd.x0[XY_W-1]) begin
          x <= -cmd.x0;
          y <= -cmd.y0;
          z <= cmd.y0[XY_W-1] ? -HALF_TURN_FINE : HALF_TURN_FINE;
        end else begin
          x <= cmd.x0;
          y <= cmd.y0;
          z <= cmd.z0;
        end
      end else if (busy) begin
        if (plus) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + tab;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - tab;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.x = x;
  assign res.y = y;
  assign res.z = zflag ? '0 : z;

endmodule

// ===== src/acf_isqrt.sv =====
module acf_isqrt
  import acf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] n,
  output logic        done,
  output logic [15:0] root
);

  logic [31:0] xr;
  logic [31:0] res;
  logic [3:0] k;
  logic busy;

  logic [31:0] bitv;
  logic [32:0] trial;
  logic take;
  logic [31:0] xr_next;
  logic [31:0] res_next;

  assign bitv = 32'd1 << {k, 1'b0};
  assign trial = {1'b0, res} + {1'b0, bitv};
  assign take = {1'b0, xr} >= trial;
  assign xr_next = take ? xr - trial[31:0] : xr;
  assign res_next = take ? (res >> 1) + bitv : res >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        xr <= n;
        res <= '0;
        k <= 4'd15;
      end else if (busy) begin
        xr <= xr_next;
        res <= res_next;
        k <= k - 1'b1;
        if (k == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          root <= (xr_next > res_next) ? 16'(res_next + 32'd1) : res_next[15:0];
        end
      end
    end
  end

endmodule

// ===== src/attitude_complementary_filter.sv =====
// Attitude filter: one sensor beat in, one attitude beat out. Each beat runs through a
// sequencer that reuses one 33x33 multiplier, one iterative CORDIC unit (five operations
// per beat) and a 16-step square root unit.
// The sequence runs longer when the accel blend runs than when it is skipped, and the
// first beat is shorter still. Every extra wrap of an angle adds a pass through S_WRAP,
// most of them when a large gyro yaw step wraps, and a result that is still unread holds
// the sequencer in its last state. Most of the time goes to the CORDIC unit. The first
// beat after reset only loads the attitude and returns attitude_valid 0 with all fields
// zero. The input is ready while the sequencer is idle; a finished result waits in the
// output register.
module attitude_complementary_filter
  import acf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  acf_in_if.sink      sensor,
  acf_out_if.source   attitude,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] gyro_weight;
  logic [15:0] sample_period;
  logic signed [14:0] declination;
  logic [15:0] heading_weight;

  acf_state_t state;
  acf_state_t ret;

  logic signed [15:0] ax, ay, az, gx, gy, gz, mx, my, mz;
  logic started;
  logic init_item;
  logic [31:0] sum;
  logic [15:0] sq_syz;
  logic signed [15:0] roll_acc, pitch_acc;
  logic signed [15:0] roll, pitch, yaw, hdg, yp;
  logic signed [19:0] rg, pg, w;
  logic neg;
  logic signed [31:0] cr, sr, cp, sp, t1, t2;
  logic signed [49:0] mxc;
  logic signed [PROD_W-1:0] acc, prod;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  acf_cordic_cmd_t ccmd;
  acf_cordic_res_t cres;
  logic sq_start;
  logic [31:0] sq_n;
  logic sq_done;
  logic [15:0] sq_root;

  logic [16:0] gwc;
  logic signed [PROD_W-1:0] r14, r16, r30, bsum, bl16;
  logic signed [Z_W-1:0] zr;
  logic signed [15:0] atan_ang;
  logic signed [19:0] wf;
  logic fold;
  logic gate;
  logic signed [15:0] rg_sat, pg_sat;
  logic signed [PROD_W-1:0] mxr, myr;

  acf_cordic u_cordic (.clk(clk), .rst(rst), .cmd(ccmd), .res(cres));
  acf_isqrt u_isqrt (.clk(clk), .rst(rst), .start(sq_start), .n(sq_n), .done(sq_done),
                     .root(sq_root));

  assign gwc = 17'd65536 - {1'b0, gyro_weight};
  assign r14 = (prod + 66'sd8192) >>> 14;
  assign r16 = (prod + 66'sd32768) >>> 16;
  assign r30 = (prod + 66'sd536870912) >>> 30;
  assign bsum = acc + prod;
  assign bl16 = (bsum + 66'sd32768) >>> 16;
  assign zr = (cres.z + 27'sd512) >>> 10;
  assign atan_ang = (zr > 27'sd11520) ? 16'sd11520 :
                    (zr < -27'sd11520) ? -16'sd11520 : zr[15:0];
  assign fold = (w > QUARTER_TURN) || (w < -QUARTER_TURN);
  assign wf = (w > QUARTER_TURN) ? w - HALF_TURN :
              (w < -QUARTER_TURN) ? w + HALF_TURN : w;
  assign gate = (sum > 32'd1048576) && (sum < 32'd9437184);
  assign rg_sat = (rg > 20'sd32767) ? 16'sd32767 : (rg < -20'sd32768) ? -16'sd32768 : rg[15:0];
  assign pg_sat = (pg > 20'sd32767) ? 16'sd32767 : (pg < -20'sd32768) ? -16'sd32768 : pg[15:0];
  assign mxr = (66'(mxc) + 66'sd32768) >>> 16;
  assign myr = (acc + 66'sd32768) >>> 16;

  assign sensor.ready = (state == S_IDLE);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ1: begin mul_a = 33'(ay); mul_b = 33'(ay); end
      S_SQ2: begin mul_a = 33'(az); mul_b = 33'(az); end
      S_SQ3: begin mul_a = 33'(ax); mul_b = 33'(ax); end
      S_GX:  begin mul_a = 33'(gx); mul_b = 33'(sample_period); end
      S_GX2: begin mul_a = 33'(gy); mul_b = 33'(sample_period); end
      S_BL1: begin mul_a = 33'(gyro_weight); mul_b = 33'(rg); end
      S_BL2: begin mul_a = 33'(gwc); mul_b = 33'(roll_acc); end
      S_BL3: begin mul_a = 33'(gyro_weight); mul_b = 33'(pg); end
      S_BL4: begin mul_a = 33'(gwc); mul_b = 33'(pitch_acc); end
      S_HM1: begin mul_a = 33'(mx); mul_b = 33'(cp); end
      S_HM2: begin mul_a = 33'(mz); mul_b = 33'(sp); end
      S_HM3: begin mul_a = 33'(sr); mul_b = 33'(sp); end
      S_HM4: begin mul_a = 33'(sr); mul_b = 33'(cp); end
      S_HM5: begin mul_a = 33'(my); mul_b = 33'(cr); end
      S_HM6: begin mul_a = 33'(mx); mul_b = 33'(t1); end
      S_HM7: begin mul_a = 33'(mz); mul_b = 33'(t2); end
      S_YW0: begin mul_a = 33'(gz); mul_b = 33'(sample_period); end
      S_YW3: begin mul_a = 33'(heading_weight); mul_b = 33'(w); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    ccmd = '0;
    sq_start = 1'b0;
    sq_n = '0;
    case (state)
      S_SQ4: begin
        sq_start = 1'b1;
        sq_n = acc[31:0];
      end
      S_RT1: begin
        sq_start = sq_done;
        sq_n = sum;
        ccmd.start = sq_done;
        ccmd.vec = 1'b1;
        ccmd.x0 = {{6{az[15]}}, az, 14'd0};
        ccmd.y0 = {{6{ay[15]}}, ay, 14'd0};
      end
      S_RT2: begin
        ccmd.start = cres.done;
        ccmd.vec = 1'b1;
        ccmd.x0 = {6'd0, sq_syz, 14'd0};
        ccmd.y0 = -{{6{ax[15]}}, ax, 14'd0};
      end
      S_SC1, S_SC3: begin
        ccmd.start = 1'b1;
        ccmd.x0 = CORDIC_K;
        ccmd.z0 = {wf[16:0], 10'd0};
      end
      S_HM9: begin
        ccmd.start = 1'b1;
        ccmd.vec = 1'b1;
        ccmd.x0 = mxr[XY_W-1:0];
        ccmd.y0 = -myr[XY_W-1:0];
      end
      default: ccmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_weight <= 16'd64225;
      sample_period <= 16'd655;
      declination <= '0;
      heading_weight <= 16'd3277;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GYRO_WEIGHT:    gyro_weight <= cfg_data;
        REG_SAMPLE_PERIOD:  sample_period <= cfg_data;
        REG_DECLINATION:    declination <= cfg_data[14:0];
        REG_HEADING_WEIGHT: heading_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      started <= 1'b0;
      roll <= '0;
      pitch <= '0;
      yaw <= '0;
      attitude.valid <= 1'b0;
    end else begin
      if (attitude.ready && state != S_DONE) attitude.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (sensor.valid) begin
            ax <= sensor.accel_x; ay <= sensor.accel_y; az <= sensor.accel_z;
            gx <= sensor.gyro_x; gy <= sensor.gyro_y; gz <= sensor.gyro_z;
            mx <= sensor.mag_x; my <= sensor.mag_y; mz <= sensor.mag_z;
            init_item <= !started;
            state <= S_SQ1;
          end
        end
        S_SQ1: state <= S_SQ2;
        S_SQ2: begin acc <= prod; state <= S_SQ3; end
        S_SQ3: begin acc <= acc + prod; state <= S_SQ4; end
        S_SQ4: begin
          sum <= bsum[31:0];
          state <= S_RT1;
        end
        S_RT1: begin
          if (sq_done) begin
            sq_syz <= sq_root;
            state <= S_RT2;
          end
        end
        S_RT2: begin
          if (cres.done) begin
            roll_acc <= atan_ang;
            state <= S_RT3;
          end
        end
        S_RT3: begin
          if (cres.done) begin
            pitch_acc <= atan_ang;
            if (!started) begin
              roll <= roll_acc;
              pitch <= atan_ang;
              state <= S_SC0;
            end else begin
              state <= S_GX;
            end
          end
        end
        S_GX: state <= S_GX2;
        S_GX2: begin rg <= 20'(roll) + r14[19:0]; state <= S_GY2; end
        S_GY2: begin
          pg <= 20'(pitch) + r14[19:0];
          state <= gate ? S_BL1 : S_SAT;
        end
        S_BL1: state <= S_BL2;
        S_BL2: begin acc <= prod; state <= S_BL3; end
        S_BL3: begin rg <= bl16[19:0]; state <= S_BL4; end
        S_BL4: begin acc <= prod; state <= S_BL5; end
        S_BL5: begin pg <= bl16[19:0]; state <= S_SAT; end
        S_SAT: begin
          roll <= rg_sat;
          pitch <= pg_sat;
          state <= S_SC0;
        end
        S_SC0: begin
          w <= 20'(roll);
          ret <= S_SC1;
          state <= S_WRAP;
        end
        S_SC1: begin neg <= fold; state <= S_SC2; end
        S_SC2: begin
          if (cres.done) begin
            cr <= neg ? -cres.x[31:0] : cres.x[31:0];
            sr <= neg ? -cres.y[31:0] : cres.y[31:0];
            w <= 20'(pitch);
            ret <= S_SC3;
            state <= S_WRAP;
          end
        end
        S_SC3: begin neg <= fold; state <= S_SC4; end
        S_SC4: begin
          if (cres.done) begin
            cp <= neg ? -cres.x[31:0] : cres.x[31:0];
            sp <= neg ? -cres.y[31:0] : cres.y[31:0];
            state <= S_HM1;
          end
        end
        S_WRAP: begin
          if (w > HALF_TURN) w <= w - TURN;
          else if (w < -HALF_TURN) w <= w + TURN;
          else state <= ret;
        end
        S_HM1: state <= S_HM2;
        S_HM2: begin acc <= prod; state <= S_HM3; end
        S_HM3: begin mxc <= bsum[49:0]; state <= S_HM4; end
        S_HM4: begin t1 <= r30[31:0]; state <= S_HM5; end
        S_HM5: begin t2 <= r30[31:0]; state <= S_HM6; end
        S_HM6: begin acc <= prod; state <= S_HM7; end
        S_HM7: begin acc <= bsum; state <= S_HM8; end
        S_HM8: begin acc <= acc - prod; state <= S_HM9; end
        S_HM9: state <= S_HW;
        S_HW: begin
          if (cres.done) begin
            w <= 20'(atan_ang) + 20'(declination);
            ret <= S_YW0;
            state <= S_WRAP;
          end
        end
        S_YW0: begin
          hdg <= w[15:0];
          if (!started) begin
            yaw <= w[15:0];
            started <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_YW1;
          end
        end
        S_YW1: begin
          w <= 20'(yaw) + r14[19:0];
          ret <= S_YW2;
          state <= S_WRAP;
        end
        S_YW2: begin
          yp <= w[15:0];
          w <= 20'(hdg) - w;
          ret <= S_YW3;
          state <= S_WRAP;
        end
        S_YW3: state <= S_YW4;
        S_YW4: begin
          w <= 20'(yp) + r16[19:0];
          ret <= S_YW5;
          state <= S_WRAP;
        end
        S_YW5: begin yaw <= w[15:0]; state <= S_DONE; end
        S_DONE: begin
          if (!attitude.valid || attitude.ready) begin
            attitude.valid <= 1'b1;
            attitude.attitude_valid <= !init_item;
            attitude.roll_out <= init_item ? '0 : roll;
            attitude.pitch_out <= init_item ? '0 : pitch;
            attitude.yaw_out <= init_item ? '0 : yaw[14:0];
            attitude.roll_rate <= init_item ? '0 : gx;
            attitude.pitch_rate <= init_item ? '0 : gy;
            attitude.yaw_rate <= init_item ? '0 : gz;
            attitude.accel_magnitude <= init_item ? '0 : sq_root;
            attitude.mag_heading <= init_item ? '0 : hdg[14:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    sensor.valid && sensor.ready |=> state == S_SQ1)
    else $error("accepted beat did not start the sequence");

  a_started_holds: assert property (@(posedge clk) disable iff (rst)
    !$fell(started))
    else $error("started flag dropped");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(attitude.valid) |-> $past(state == S_DONE))
    else $error("result raised outside completion");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    attitude.valid && attitude.attitude_valid |->
      (attitude.yaw_out <= 15'sd11520) && (attitude.yaw_out >= -15'sd11520))
    else $error("yaw out of range");

  a_cordic_done_waited: assert property (@(posedge clk) disable iff (rst)
    cres.done |-> (state == S_RT2 || state == S_RT3 || state == S_SC2 ||
                   state == S_SC4 || state == S_HW))
    else $error("CORDIC result arrived in a non-waiting state");

endmodule
